// ----- hdl/greedy_mac_mode_pairing_assert.svh -----
// Assertion macros shared by the pairing block.
`ifndef GREEDY_MAC_MODE_PAIRING_ASSERT_SVH
`define GREEDY_MAC_MODE_PAIRING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/gmp_pkg.sv -----
package gmp_pkg;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 1024;

	localparam int VAL_W = 18;
	localparam int COL_W = 6;
	localparam int ROW_W = 10;
	localparam int CNT_W = $clog2(MAX_COLS + 1);
	localparam int COL_IDX_W = $clog2(MAX_COLS);
	localparam int ROW_CNT_W = $clog2(MAX_ROWS);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_THRESHOLD = '0;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    row_end;
		logic                    new_matrix;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_index;
		logic             matched;
		logic [COL_W-1:0] column;
		logic [VAL_W-1:0] best_value;
	} res_t;

	typedef struct packed {
		logic [VAL_W-1:0] mag;
		logic [COL_W-1:0] col;
		logic             in_range;
		logic             first;
		logic             new_matrix;
		logic             row_end;
		logic [ROW_W-1:0] row_index;
	} work_t;

endpackage

// ----- hdl/gmp_front.sv -----
module gmp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  gmp_pkg::item_t item,
	input  logic          queue_full,
	output logic          push,
	output gmp_pkg::work_t work
);

	logic [gmp_pkg::CNT_W-1:0]     col_cnt_q;
	logic [gmp_pkg::ROW_CNT_W-1:0] row_cnt_q;
	logic [gmp_pkg::CNT_W-1:0]     col_eff;
	logic [gmp_pkg::ROW_CNT_W-1:0] row_eff;
	logic                          in_range;
	logic [gmp_pkg::VAL_W:0]       vext;

	assign push     = item_valid && !queue_full;
	assign col_eff  = item.new_matrix ? '0 : col_cnt_q;
	assign row_eff  = item.new_matrix ? '0 : row_cnt_q;
	assign in_range = col_eff < gmp_pkg::CNT_W'(gmp_pkg::MAX_COLS);
	assign vext     = {item.value[gmp_pkg::VAL_W-1], item.value};

	always_comb begin
		work.mag        = item.value[gmp_pkg::VAL_W-1] ?
			gmp_pkg::VAL_W'(~vext + (gmp_pkg::VAL_W+1)'(1)) : gmp_pkg::VAL_W'(item.value);
		work.col        = gmp_pkg::COL_W'(col_eff);
		work.in_range   = in_range;
		work.first      = (col_eff == '0);
		work.new_matrix = item.new_matrix;
		work.row_end    = item.row_end;
		work.row_index  = gmp_pkg::ROW_W'(row_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (push) begin
			if (item.row_end) begin
				col_cnt_q <= '0;
				if (row_eff == gmp_pkg::ROW_CNT_W'(gmp_pkg::MAX_ROWS - 1)) begin
					row_cnt_q <= '0;
				end else begin
					row_cnt_q <= row_eff + gmp_pkg::ROW_CNT_W'(1);
				end
			end else begin
				row_cnt_q <= row_eff;
				col_cnt_q <= in_range ? col_eff + gmp_pkg::CNT_W'(1) : col_eff;
			end
		end
	end

endmodule

// ----- hdl/gmp_queue.sv -----
module gmp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gmp_pkg::work_t wr_data,
	input  logic           pop,
	output logic           full,
	output logic           nonempty,
	output gmp_pkg::work_t head
);

	gmp_pkg::work_t                mem_q [gmp_pkg::QUEUE_DEPTH];
	logic [gmp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [gmp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [gmp_pkg::QPTR_W:0]      count_q;

	assign full     = (count_q == (gmp_pkg::QPTR_W+1)'(gmp_pkg::QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gmp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gmp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (gmp_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (gmp_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- hdl/gmp_back.sv -----
`include "greedy_mac_mode_pairing_assert.svh"

module gmp_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            nonempty,
	input  gmp_pkg::work_t                  head,
	input  logic signed [gmp_pkg::VAL_W-1:0] threshold,
	output logic                            pop,
	output logic                            res_valid,
	output gmp_pkg::res_t                   res,
	input  logic                            res_stall
);

	logic [gmp_pkg::MAX_COLS-1:0] mask_q;
	logic signed [gmp_pkg::VAL_W:0] rmax_q;
	logic [gmp_pkg::COL_W-1:0]    best_q;
	logic                         found_q;
	logic                         res_valid_q;
	gmp_pkg::res_t                res_q;

	logic [gmp_pkg::MAX_COLS-1:0] mask_eff;
	logic signed [gmp_pkg::VAL_W:0] rmax_eff;
	logic signed [gmp_pkg::VAL_W:0] mag_ext;
	logic                         hit;
	logic signed [gmp_pkg::VAL_W:0] rmax_next;
	logic [gmp_pkg::COL_W-1:0]    best_next;
	logic                         found_next;
	logic                         out_free;

	assign out_free = !res_valid_q || !res_stall;
	assign pop      = nonempty && (!head.row_end || out_free);

	assign mask_eff = head.new_matrix ? '0 : mask_q;
	assign rmax_eff = head.first ? {threshold[gmp_pkg::VAL_W-1], threshold} : rmax_q;
	assign mag_ext  = $signed({1'b0, head.mag});
	assign hit      = head.in_range && !mask_eff[head.col[gmp_pkg::COL_IDX_W-1:0]] &&
		(mag_ext > rmax_eff);

	assign rmax_next  = hit ? mag_ext : rmax_eff;
	assign best_next  = hit ? head.col : (head.first ? '0 : best_q);
	assign found_next = hit || (!head.first && found_q);

	always_ff @(posedge clk) begin
		if (pop) begin
			rmax_q <= rmax_next;
			best_q <= best_next;
		end
		if (pop && head.row_end) begin
			res_q.row_index  <= head.row_index;
			res_q.matched    <= found_next;
			res_q.column     <= found_next ? best_next : '0;
			res_q.best_value <= found_next ? gmp_pkg::VAL_W'(rmax_next) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				found_q <= found_next;
				if (head.row_end && found_next) begin
					mask_q <= mask_eff |
						(gmp_pkg::MAX_COLS'(1) << best_next[gmp_pkg::COL_IDX_W-1:0]);
				end else begin
					mask_q <= mask_eff;
				end
			end
			if (pop && head.row_end) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`GMP_ASSERT_NOW(a_unmatched_zero, res_valid_q && !res_q.matched,
		res_q.column == '0 && res_q.best_value == '0, "unmatched word carries data")
	`GMP_ASSERT_NEXT(a_mask_marked, pop && head.row_end && found_next,
		mask_q[$past(best_next[gmp_pkg::COL_IDX_W-1:0])], "paired column not marked taken")
	`GMP_ASSERT_NOW(a_word_source, $rose(res_valid_q),
		$past(pop && head.row_end), "result word without a finished row")

endmodule

// ----- hdl/greedy_mac_mode_pairing.sv -----
// Greedy row-maximum pairing over a criterion matrix streamed row by row.
// Input channel (item_valid, item_stall, item): one signed Q1.16 element per
// word, with row_end closing a row and new_matrix clearing the taken columns
// and the row count before the word is handled.
// Output channel (res_valid, res_stall, res): one word per finished row with
// the row index and, when a pairing exists, the column and its magnitude.
// The threshold register is written through the APB port at address 0.
// Throughput is one input word per cycle while item_stall is low; the column
// search pops one queued element per cycle, a row end only when out_free.
// A row's last word is written into the queue, and its result word is
// registered in the back end when it is popped from the queue head.
// A four-deep queue sits between the front end and the back end, so a
// stalled receiver holds the result word and the queue keeps taking words
// until it fills, after which item_stall is raised.
// Reset clears the taken columns, the counters, the queue and the
// threshold; the block accepts words in the first cycle after reset.
module greedy_mac_mode_pairing (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  gmp_pkg::item_t                 item,
	output logic                           res_valid,
	input  logic                           res_stall,
	output gmp_pkg::res_t                  res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gmp_pkg::PADDR_W-1:0]    paddr,
	input  logic [gmp_pkg::PDATA_W-1:0]    pwdata,
	output logic [gmp_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	logic signed [gmp_pkg::VAL_W-1:0] threshold_q;
	logic                             push;
	logic                             pop;
	logic                             queue_full;
	logic                             nonempty;
	gmp_pkg::work_t                   work;
	gmp_pkg::work_t                   head;
	logic [gmp_pkg::PADDR_W-3:0]      reg_idx;

	assign pready     = 1'b1;
	assign reg_idx    = paddr[gmp_pkg::PADDR_W-1:2];
	assign item_stall = queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (psel && penable && pwrite && pready &&
				reg_idx == gmp_pkg::REG_THRESHOLD) begin
			threshold_q <= $signed(pwdata[gmp_pkg::VAL_W-1:0]);
		end
	end

	always_comb begin
		if (reg_idx == gmp_pkg::REG_THRESHOLD) begin
			prdata = {{(gmp_pkg::PDATA_W-gmp_pkg::VAL_W){threshold_q[gmp_pkg::VAL_W-1]}},
				threshold_q};
		end else begin
			prdata = '0;
		end
	end

	gmp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.work       (work)
	);

	gmp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (work),
		.pop      (pop),
		.full     (queue_full),
		.nonempty (nonempty),
		.head     (head)
	);

	gmp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nonempty  (nonempty),
		.head      (head),
		.threshold (threshold_q),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (res),
		.res_stall (res_stall)
	);

endmodule

// ----- sim/greedy_mac_mode_pairing_checker.sv -----
`timescale 1ns / 100ps

module greedy_mac_mode_pairing_checker
	import gmp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  item_t               item,
	input  logic                res_valid,
	input  logic                res_stall,
	input  res_t                res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic                pready,
	output int                  errors,
	output int                  outstanding
);

	localparam logic [PADDR_W-1:0] THRESH_ADDR = {REG_THRESHOLD, 2'b00};

	int              threshold_q;
	logic [63:0]     taken;
	int              col_cnt;
	int              row_cnt;
	int              run_max;
	int              best_col;
	bit              found;
	res_t            pairings_due[$];
	int              err_cnt = 0;

	// Applies one element to the pairing state and queues the row's result word
	// when the element closes a row.
	function automatic void pair_element(input item_t w);
		int   mag;
		res_t r;
		mag = (w.value < 0) ? -int'(w.value) : int'(w.value);
		if (w.new_matrix) begin
			taken = '0;
			row_cnt = 0;
			col_cnt = 0;
			found = 1'b0;
			best_col = 0;
		end
		if (col_cnt == 0)
			run_max = threshold_q;
		if (col_cnt < MAX_COLS) begin
			if (mag > run_max && !taken[col_cnt]) begin
				run_max = mag;
				best_col = col_cnt;
				found = 1'b1;
			end
			col_cnt++;
		end
		if (w.row_end) begin
			r.row_index = ROW_W'(row_cnt);
			r.matched = found;
			r.column = found ? COL_W'(best_col) : '0;
			r.best_value = found ? VAL_W'(run_max) : '0;
			if (found)
				taken[best_col] = 1'b1;
			pairings_due = {pairings_due, r};
			row_cnt = (row_cnt + 1 >= MAX_ROWS) ? 0 : row_cnt + 1;
			col_cnt = 0;
			found = 1'b0;
			best_col = 0;
		end
	endfunction

	function automatic void compare_result(input res_t want, input res_t got);
		if (got.row_index !== want.row_index) begin
			$error("row_index expected %0d actual %0d", want.row_index, got.row_index);
			err_cnt++;
		end
		if (got.matched !== want.matched) begin
			$error("matched expected %0d actual %0d", want.matched, got.matched);
			err_cnt++;
		end
		if (got.column !== want.column) begin
			$error("column expected %0d actual %0d", want.column, got.column);
			err_cnt++;
		end
		if (got.best_value !== want.best_value) begin
			$error("best_value expected %0d actual %0d", want.best_value, got.best_value);
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q = 0;
			taken = '0;
			col_cnt = 0;
			row_cnt = 0;
			run_max = 0;
			best_col = 0;
			found = 1'b0;
			pairings_due.delete();
			outstanding <= 0;
			errors <= err_cnt;
		end else begin
			if (psel && penable && pwrite && pready && paddr == THRESH_ADDR)
				threshold_q = $signed(pwdata[VAL_W-1:0]);
			// A result word accepted at this edge cannot stem from a word
			// accepted at the same edge, so results are retired first.
			if (res_valid && !res_stall) begin
				if (pairings_due.size() == 0) begin
					$error("unexpected result word, row_index actual %0d", res.row_index);
					err_cnt++;
				end else begin
					compare_result(pairings_due.pop_front(), res);
				end
			end
			if (item_valid && !item_stall)
				pair_element(item);
			outstanding <= pairings_due.size();
			errors <= err_cnt;
		end
	end

endmodule

// ----- sim/tb_greedy_mac_mode_pairing.sv -----
`timescale 1ns / 100ps

module tb_greedy_mac_mode_pairing;
	import gmp_pkg::*;

	localparam logic [PADDR_W-1:0] THRESH_ADDR = {REG_THRESHOLD, 2'b00};
	localparam int STALL_LIMIT = 5000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_t               item = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	res_t                res;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	int                  fail_count;
	int                  due_count;
	int                  idle_pct = 0;
	int                  stall_pct = 0;
	int                  quiet_cycles = 0;

	greedy_mac_mode_pairing u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	greedy_mac_mode_pairing_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.errors      (fail_count),
		.outstanding (due_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall) ||
				(psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("greedy_mac_mode_pairing verification failed");
			$finish;
		end
	end

	function automatic logic signed [VAL_W-1:0] rand_value();
		int s;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {1'b0, {(VAL_W-1){1'b1}}};
			2: return {1'b1, {(VAL_W-1){1'b0}}};
			3, 4: begin
				s = int'($urandom_range(0, 600)) - 300;
				return s[VAL_W-1:0];
			end
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic int row_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			return $urandom_range(1, 6);
		else if (pick < 95)
			return $urandom_range(7, 20);
		else
			return $urandom_range(MAX_COLS - 4, MAX_COLS + 6);
	endfunction

	task automatic send_word(input item_t w);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_element(input int v, input bit last, input bit fresh);
		item_t w;
		w.value = v[VAL_W-1:0];
		w.row_end = last;
		w.new_matrix = fresh;
		send_word(w);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input int th);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= THRESH_ADDR;
		pwdata <= PDATA_W'(th);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reconfigure(input int th, input int idle, input int stall);
		drain();
		repeat (8) @(posedge clk);
		write_threshold(th);
		idle_pct = idle;
		stall_pct <= stall;
	endtask

	task automatic run_phase(input int n_words, input int th, input int idle,
			input int stall, input bit pause_once);
		int    sent;
		int    rows_left;
		int    len;
		bit    fresh;
		item_t w;
		sent = 0;
		rows_left = 0;
		reconfigure(th, idle, stall);
		while (sent < n_words) begin
			if (pause_once && sent >= n_words / 2) begin
				pause_once = 1'b0;
				drain();
			end
			fresh = (rows_left == 0);
			if (fresh)
				rows_left = $urandom_range(1, 12);
			rows_left--;
			len = row_length();
			for (int i = 0; i < len; i++) begin
				w.value = rand_value();
				w.row_end = (i == len - 1);
				w.new_matrix = (i == 0 && fresh) || ($urandom_range(0, 99) < 2);
				send_word(w);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Threshold is zero out of reset.
		send_element(0, 1'b1, 1'b1);
		send_element(100, 1'b0, 1'b0);
		send_element(-131072, 1'b0, 1'b0);
		send_element(131071, 1'b1, 1'b0);
		send_element(7, 1'b0, 1'b0);
		send_element(-7, 1'b0, 1'b0);
		send_element(7, 1'b1, 1'b0);
		send_element(-131072, 1'b0, 1'b0);
		send_element(50, 1'b1, 1'b0);
		send_element(1, 1'b0, 1'b0);
		send_element(1, 1'b0, 1'b0);
		send_element(200, 1'b1, 1'b0);
		send_element(-5, 1'b0, 1'b1);
		send_element(9, 1'b1, 1'b0);
		send_element(-3, 1'b0, 1'b0);
		send_element(-3, 1'b0, 1'b1);
		send_element(131071, 1'b1, 1'b0);

		run_phase(85, 0, 0, 0, 1'b0);
		run_phase(85, -131072, 80, 0, 1'b0);
		run_phase(85, 131071, 0, 80, 1'b0);
		run_phase(85, 'h4000, 34, 34, 1'b1);
		run_phase(85, -1, 0, 0, 1'b0);
		run_phase(85, int'($urandom_range(0, 'h3FFFF)) - 'h20000, 34, 34, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && due_count == 0)
			$display("greedy_mac_mode_pairing verification clean");
		else
			$display("greedy_mac_mode_pairing verification failed");
		$finish;
	end

endmodule
